[sv/mlp221_pkg.sv]
// Package for the 2-2-1 sigmoid network trainer: payload types, sequencer step codes,
// datapath widths, the sigmoid table and the weight saturation helper.
// No dependencies.
package mlp221_pkg;

	// Weight storage width and sigmoid table size (table size must be a power of two)
	localparam int WEIGHT_W = 16;
	localparam int SIG_DEPTH = 256;
	localparam int SIG_LOG2 = $clog2(SIG_DEPTH);

	// Datapath widths, all derived from the weight width
	localparam int TMP_W = WEIGHT_W + 6;
	localparam int MUL_A_W = TMP_W;
	localparam int MUL_B_W = (WEIGHT_W > 18) ? WEIGHT_W : 18;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W = PROD_W + 1;

	localparam int STEP_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	typedef logic signed [WEIGHT_W-1:0] wt_t;
	typedef logic signed [MUL_A_W-1:0] opa_t;
	typedef logic signed [MUL_B_W-1:0] opb_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [TMP_W-1:0] tmp_t;

	typedef struct packed {
		logic              func;
		logic signed [15:0] in_a;
		logic signed [15:0] in_b;
		logic [12:0]        target;
		logic [3:0]         weight_index;
		logic signed [15:0] weight_value;
	} req_t;

	typedef struct packed {
		logic [12:0] prediction;
		logic [12:0] squared_error;
	} res_t;

	// Request function codes
	localparam logic FUNC_TRAIN = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGMOID_GAIN = 1'b1;
	localparam logic [11:0] LEARN_RATE_RST = 12'd410;
	localparam logic [15:0] SIGMOID_GAIN_RST = 16'd16384;

	// Weight file layout
	localparam logic [3:0] W_COUNT = 4'd9;
	localparam logic [3:0] WI_OUT_H1 = 4'd6;

	// Neuron / update group index
	localparam logic [1:0] NRN_H1 = 2'd0;
	localparam logic [1:0] NRN_H2 = 2'd1;
	localparam logic [1:0] NRN_OUT = 2'd2;

	localparam logic [12:0] ONE_Q12_U = 13'd4096;
	localparam logic signed [13:0] ONE_Q12 = 14'sd4096;

	// Sequencer steps
	localparam logic [STEP_W-1:0] ST_IDLE = 5'd0;
	localparam logic [STEP_W-1:0] ST_M0   = 5'd1;
	localparam logic [STEP_W-1:0] ST_M1   = 5'd2;
	localparam logic [STEP_W-1:0] ST_NET  = 5'd3;
	localparam logic [STEP_W-1:0] ST_Z    = 5'd4;
	localparam logic [STEP_W-1:0] ST_LO   = 5'd5;
	localparam logic [STEP_W-1:0] ST_DIF  = 5'd6;
	localparam logic [STEP_W-1:0] ST_ACT  = 5'd7;
	localparam logic [STEP_W-1:0] ST_ERR  = 5'd8;
	localparam logic [STEP_W-1:0] ST_SQ   = 5'd9;
	localparam logic [STEP_W-1:0] ST_DO0  = 5'd10;
	localparam logic [STEP_W-1:0] ST_DO1  = 5'd11;
	localparam logic [STEP_W-1:0] ST_DO2  = 5'd12;
	localparam logic [STEP_W-1:0] ST_DH0  = 5'd13;
	localparam logic [STEP_W-1:0] ST_DH1  = 5'd14;
	localparam logic [STEP_W-1:0] ST_DH2  = 5'd15;
	localparam logic [STEP_W-1:0] ST_DH3  = 5'd16;
	localparam logic [STEP_W-1:0] ST_G    = 5'd17;
	localparam logic [STEP_W-1:0] ST_U0   = 5'd18;
	localparam logic [STEP_W-1:0] ST_U1   = 5'd19;
	localparam logic [STEP_W-1:0] ST_U2   = 5'd20;
	localparam logic [STEP_W-1:0] ST_WRES = 5'd21;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [1:0]        nrn;
		logic              take;
		logic              emit;
	} ctl_t;

	localparam prod_t W_HI = PROD_W'((64'sd1 <<< (WEIGHT_W - 1)) - 64'sd1);
	localparam prod_t W_LO = -W_HI - PROD_W'(1);

	function automatic wt_t sat_w(input prod_t v);
		wt_t r;
		if (v > W_HI) begin
			r = WEIGHT_W'(W_HI);
		end else if (v < W_LO) begin
			r = WEIGHT_W'(W_LO);
		end else begin
			r = WEIGHT_W'(v);
		end
		return r;
	endfunction

	// Exponent step 8/D in Q.32; table points lie two steps, 16/D, apart
	localparam longint unsigned SIG_STEP_Q32 = (64'd1 << 35) / SIG_DEPTH;

	// Restoring long division, only evaluated while building the table
	function automatic longint unsigned udiv_u64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned rem;
		int i;
		q = '0;
		rem = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sigmoid points over [-8,+8]: e^-t by a power series, then 1/(1+e^-t) in Q.12
	typedef logic [SIG_DEPTH:0][12:0] sig_tab_t;

	function automatic sig_tab_t build_sig_tab();
		sig_tab_t tab;
		longint unsigned h;
		longint unsigned term;
		longint unsigned r;
		longint unsigned e;
		longint unsigned den;
		longint unsigned sp;
		int n;
		int j;
		h = SIG_STEP_Q32;
		term = 64'd1 << 32;
		r = term;
		for (n = 1; n < 16; n++) begin
			term = udiv_u64((term * h) >> 32, 64'(n));
			if ((n & 1) != 0) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		e = 64'd1 << 32;
		for (j = 0; j <= SIG_DEPTH; j++) begin
			if (((SIG_DEPTH + j) & 1) == 0) begin
				den = (64'd1 << 32) + e;
				sp = udiv_u64((64'd1 << 44) + (den >> 1), den);
				tab[(SIG_DEPTH + j) >> 1] = 13'(sp);
				tab[(SIG_DEPTH - j) >> 1] = 13'(64'd4096 - sp);
			end
			e = (e * r) >> 32;
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

[sv/mlp221_seq.sv]
// Step sequencer for the 2-2-1 trainer: walks the forward pass, the delta chain and the
// weight updates one shared-multiplier step per cycle, but holds a result step while the
// output register is full, and owns both handshakes. Depends on mlp221_pkg.
module mlp221_seq import mlp221_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_func,
	output logic req_ready,
	output logic res_valid,
	input  logic res_ready,
	output ctl_t ctl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [1:0]        nrn_q;
	logic [1:0]        nrn_d;
	logic              res_valid_q;
	logic              out_free;
	logic              take;
	logic              emit;

	assign req_ready = (step_q == ST_IDLE);
	assign take = req_valid && req_ready;
	assign out_free = !res_valid_q || res_ready;
	assign emit = ((step_q == ST_SQ) || (step_q == ST_WRES)) && out_free;

	always_comb begin
		step_d = step_q;
		nrn_d = nrn_q;
		case (step_q)
			ST_IDLE: begin
				if (take) begin
					step_d = (req_func == FUNC_WRITE) ? ST_WRES : ST_M0;
					nrn_d = NRN_H1;
				end
			end
			ST_M0:  step_d = ST_M1;
			ST_M1:  step_d = ST_NET;
			ST_NET: step_d = ST_Z;
			ST_Z:   step_d = ST_LO;
			ST_LO:  step_d = ST_DIF;
			ST_DIF: step_d = ST_ACT;
			ST_ACT: begin
				if (nrn_q == NRN_OUT) begin
					step_d = ST_ERR;
					nrn_d = NRN_H1;
				end else begin
					step_d = ST_M0;
					nrn_d = nrn_q + 2'd1;
				end
			end
			ST_ERR: step_d = ST_SQ;
			ST_SQ: begin
				// hold until the output register can take the result
				if (out_free) begin
					step_d = ST_DO0;
				end
			end
			ST_DO0: step_d = ST_DO1;
			ST_DO1: step_d = ST_DO2;
			ST_DO2: step_d = ST_DH0;
			ST_DH0: step_d = ST_DH1;
			ST_DH1: step_d = ST_DH2;
			ST_DH2: step_d = ST_DH3;
			ST_DH3: begin
				if (nrn_q == NRN_H2) begin
					step_d = ST_G;
					nrn_d = NRN_H1;
				end else begin
					step_d = ST_DH0;
					nrn_d = NRN_H2;
				end
			end
			ST_G:  step_d = ST_U0;
			ST_U0: step_d = ST_U1;
			ST_U1: step_d = ST_U2;
			ST_U2: begin
				if (nrn_q == NRN_OUT) begin
					step_d = ST_IDLE;
					nrn_d = NRN_H1;
				end else begin
					step_d = ST_G;
					nrn_d = nrn_q + 2'd1;
				end
			end
			ST_WRES: begin
				if (out_free) begin
					step_d = ST_IDLE;
				end
			end
			default: begin
				step_d = ST_IDLE;
				nrn_d = NRN_H1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			nrn_q <= NRN_H1;
			res_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			nrn_q <= nrn_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign ctl.step = step_q;
	assign ctl.nrn = nrn_q;
	assign ctl.take = take;
	assign ctl.emit = emit;

endmodule

[sv/mlp221_dp.sv]
// Datapath for the 2-2-1 trainer: weight file, one shared signed multiplier,
// sigmoid table interpolation, delta and update registers, and the result register.
// Depends on mlp221_pkg; steered by the step codes from mlp221_seq.
module mlp221_dp import mlp221_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  req_t        req,
	input  logic [11:0] learn_rate,
	input  logic [15:0] sigmoid_gain,
	output res_t        res
);

	wt_t                 w_q [0:8];
	logic signed [15:0]  a_q;
	logic signed [15:0]  b_q;
	logic [12:0]         t_q;
	acc_t                acc_q;
	tmp_t                tmp_q;
	logic [15:0]         u_q;
	logic [12:0]         lo_q;
	logic signed [13:0]  dif_q;
	logic [12:0]         h1_q;
	logic [12:0]         h2_q;
	logic [12:0]         y_q;
	logic signed [13:0]  err_q;
	tmp_t                d_h1_q;
	tmp_t                d_h2_q;
	tmp_t                d_out_q;
	tmp_t                g_q;
	res_t                res_q;

	logic [3:0]          w_base;
	logic [3:0]          w_addr;
	wt_t                 w_rd;
	wt_t                 w_new;
	opa_t                mul_a;
	opb_t                mul_b;
	prod_t               prod;
	prod_t               psh;
	acc_t                net;
	prod_t               act_sum;
	logic [15:0]         zc;
	logic [SIG_LOG2-1:0] tab_k;
	logic [SIG_LOG2:0]   tab_k1;
	logic [15:0]         frac;
	logic [12:0]         h_sel;
	logic [12:0]         x0;
	logic [12:0]         x1;
	tmp_t                d_sel;
	logic signed [13:0]  err_d;
	logic                out_nrn;

	assign out_nrn = (ctl.nrn == NRN_OUT);

	// weight address: three weights per neuron, output-layer weights read for hidden deltas
	assign w_base = 4'({ctl.nrn, 1'b0}) + 4'(ctl.nrn);
	always_comb begin
		case (ctl.step)
			ST_M0, ST_U0:  w_addr = w_base;
			ST_M1, ST_U1:  w_addr = w_base + 4'd1;
			ST_NET, ST_U2: w_addr = w_base + 4'd2;
			ST_DH1:        w_addr = WI_OUT_H1 + 4'(ctl.nrn);
			default:       w_addr = w_base;
		endcase
	end
	assign w_rd = w_q[w_addr];

	assign tab_k = u_q[15 -: SIG_LOG2];
	assign tab_k1 = {1'b0, tab_k} + (SIG_LOG2 + 1)'(1);
	assign frac = {u_q[15-SIG_LOG2:0], {SIG_LOG2{1'b0}}};

	assign h_sel = (ctl.nrn == NRN_H2) ? h2_q : h1_q;
	assign x0 = h1_q;
	assign x1 = h2_q;

	always_comb begin
		case (ctl.nrn)
			NRN_H1:  d_sel = d_h1_q;
			NRN_H2:  d_sel = d_h2_q;
			default: d_sel = d_out_q;
		endcase
	end

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.step)
			ST_M0: begin
				mul_a = MUL_A_W'(w_rd);
				mul_b = out_nrn ? MUL_B_W'($signed({1'b0, x0})) : MUL_B_W'(a_q);
			end
			ST_M1: begin
				mul_a = MUL_A_W'(w_rd);
				mul_b = out_nrn ? MUL_B_W'($signed({1'b0, x1})) : MUL_B_W'(b_q);
			end
			ST_Z, ST_DO2, ST_DH3: begin
				mul_a = MUL_A_W'(tmp_q);
				mul_b = MUL_B_W'($signed({1'b0, sigmoid_gain}));
			end
			ST_ACT: begin
				mul_a = MUL_A_W'(dif_q);
				mul_b = MUL_B_W'($signed({1'b0, frac}));
			end
			ST_SQ: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = MUL_B_W'(err_q);
			end
			ST_DO0: begin
				mul_a = MUL_A_W'(ONE_Q12 - $signed({1'b0, y_q}));
				mul_b = MUL_B_W'($signed({1'b0, y_q}));
			end
			ST_DO1: begin
				mul_a = MUL_A_W'(tmp_q);
				mul_b = MUL_B_W'(err_q);
			end
			ST_DH0: begin
				mul_a = MUL_A_W'(ONE_Q12 - $signed({1'b0, h_sel}));
				mul_b = MUL_B_W'($signed({1'b0, h_sel}));
			end
			ST_DH1: begin
				mul_a = MUL_A_W'(tmp_q);
				mul_b = MUL_B_W'(w_rd);
			end
			ST_DH2: begin
				mul_a = MUL_A_W'(tmp_q);
				mul_b = MUL_B_W'(d_out_q);
			end
			ST_G: begin
				mul_a = MUL_A_W'(d_sel);
				mul_b = MUL_B_W'($signed({1'b0, learn_rate}));
			end
			ST_U0: begin
				mul_a = MUL_A_W'(g_q);
				mul_b = out_nrn ? MUL_B_W'($signed({1'b0, x0})) : MUL_B_W'(a_q);
			end
			ST_U1: begin
				mul_a = MUL_A_W'(g_q);
				mul_b = out_nrn ? MUL_B_W'($signed({1'b0, x1})) : MUL_B_W'(b_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign psh = prod >>> 12;

	assign net = (acc_q >>> 12) + ACC_W'(w_rd);
	assign act_sum = PROD_W'($signed({1'b0, lo_q})) + (prod >>> 16);
	assign err_d = $signed({1'b0, y_q}) - $signed({1'b0, t_q});

	// clamp the sigmoid argument to 16 bits
	always_comb begin
		if (psh > PROD_W'(32767)) begin
			zc = 16'h7FFF;
		end else if (psh < -PROD_W'(32768)) begin
			zc = 16'h8000;
		end else begin
			zc = psh[15:0];
		end
	end

	always_comb begin
		if (ctl.step == ST_U2) begin
			w_new = sat_w(PROD_W'(w_rd) - PROD_W'(g_q));
		end else begin
			w_new = sat_w(PROD_W'(w_rd) - psh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				w_q[i] <= '0;
			end
		end else if (ctl.take) begin
			if ((req.func == FUNC_WRITE) && (req.weight_index < W_COUNT)) begin
				w_q[req.weight_index] <= sat_w(PROD_W'(req.weight_value));
			end
		end else if ((ctl.step == ST_U0) || (ctl.step == ST_U1) || (ctl.step == ST_U2)) begin
			w_q[w_addr] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			a_q <= req.in_a;
			b_q <= req.in_b;
			t_q <= (req.target > ONE_Q12_U) ? ONE_Q12_U : req.target;
		end
		case (ctl.step)
			ST_M0:  acc_q <= ACC_W'(prod);
			ST_M1:  acc_q <= acc_q + ACC_W'(prod);
			ST_NET: tmp_q <= TMP_W'(net);
			ST_Z:   u_q <= {~zc[15], zc[14:0]};
			ST_LO:  lo_q <= SIG_TAB[{1'b0, tab_k}];
			ST_DIF: dif_q <= $signed({1'b0, SIG_TAB[tab_k1]}) - $signed({1'b0, lo_q});
			ST_ACT: begin
				case (ctl.nrn)
					NRN_H1:  h1_q <= act_sum[12:0];
					NRN_H2:  h2_q <= act_sum[12:0];
					default: y_q <= act_sum[12:0];
				endcase
			end
			ST_ERR: err_q <= err_d;
			ST_DO0, ST_DO1, ST_DH0, ST_DH1, ST_DH2: tmp_q <= TMP_W'(psh);
			ST_DO2: d_out_q <= TMP_W'(psh);
			ST_DH3: begin
				if (ctl.nrn == NRN_H2) begin
					d_h2_q <= TMP_W'(psh);
				end else begin
					d_h1_q <= TMP_W'(psh);
				end
			end
			ST_G: g_q <= TMP_W'(psh);
			default: begin
			end
		endcase
		// load the result register; write requests report zero
		if (ctl.emit) begin
			if (ctl.step == ST_SQ) begin
				res_q.prediction <= y_q;
				res_q.squared_error <= psh[12:0];
			end else begin
				res_q <= '0;
			end
		end
	end

	assign res = res_q;

endmodule

[sv/mlp_221_backprop_trainer.sv]
// Top level of the 2-2-1 sigmoid network trainer: configuration registers,
// sequencer and datapath. Depends on mlp221_pkg, mlp221_seq and mlp221_dp.
//
// Usage:
//   Request channel (req_valid/req_ready/req_data): func selects a training sample or
//   a weight write. A weight write stores one of nine saturated weights; an index above
//   eight is dropped. Both produce exactly one result on the result channel.
//   Result channel (res_valid/res_ready/res_data): prediction and squared error of a
//   training sample, taken before the weight update; zero for weight writes.
//   Configuration port (cfg_we/cfg_index/cfg_data): learning rate and sigmoid gain,
//   written while the block is idle.
// Timing:
//   A training sample holds the block from acceptance to the next acceptance, set by
//   the single shared multiplier: 21 forward steps, 2 error steps, 11 delta steps and
//   12 update steps, plus the accept step. Its result is registered in its squared-error
//   step, before the delta steps. A weight write's result is registered in its result step.
//   req_ready is high only between requests.
// Reset clears weights to zero and loads learning rate 410 and gain 4.0.
// A stalled result holds in the output register; a training sample then waits in its
// error step, so one result can be pending while the next one is being computed.
module mlp_221_backprop_trainer import mlp221_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [11:0] learn_rate_q;
	logic [15:0] sigmoid_gain_q;
	ctl_t        ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q <= LEARN_RATE_RST;
			sigmoid_gain_q <= SIGMOID_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEARN_RATE:   learn_rate_q <= cfg_data[11:0];
				CFG_SIGMOID_GAIN: sigmoid_gain_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	mlp221_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req_data.func),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ctl       (ctl)
	);

	mlp221_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.req          (req_data),
		.learn_rate   (learn_rate_q),
		.sigmoid_gain (sigmoid_gain_q),
		.res          (res_data)
	);

endmodule

[sv/mlp221_chk.sv]
// Port-level checker for the 2-2-1 trainer, attached to the top level by bind.
// Depends on mlp221_pkg.
module mlp221_chk import mlp221_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input req_t                  req_data,
	input logic                  res_valid,
	input logic                  res_ready,
	input res_t                  res_data,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	logic req_take;
	assign req_take = req_valid && req_ready;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// one request at a time: ready drops right after any accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> !req_ready)
		else $error("request accepted while busy");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.prediction <= 13'd4096) && (res_data.squared_error <= 13'd4096))
		else $error("result outside Q0.12 unit range");

	// a training sample cannot produce its result on the next cycle
	a_train_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req_data.func == FUNC_TRAIN) && !res_valid |=> !res_valid)
		else $error("training result appeared too early");

	// a weight write reports a zero result from the result register after its result step
	a_write_res: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req_data.func == FUNC_WRITE) && !res_valid |=> ##1
		res_valid && (res_data.prediction == 13'd0) && (res_data.squared_error == 13'd0))
		else $error("weight write result missing or nonzero");

endmodule

bind mlp_221_backprop_trainer mlp221_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req_data  (req_data),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
